### design/tlnt_pkg.sv
package tlnt_pkg;

    // Table dimensions
    localparam int MAX_USERS  = 16;
    localparam int MAX_FILES  = 16;
    localparam int NAME_BYTES = 8;

    localparam int NAME_W  = 64;
    localparam int UIDX_W  = $clog2(MAX_USERS);
    localparam int FIDX_W  = $clog2(MAX_FILES);
    localparam int UCNT_W  = $clog2(MAX_USERS + 1);
    localparam int FCNT_W  = $clog2(MAX_FILES + 1);
    localparam int FADDR_W = UIDX_W + FIDX_W;

    // Names compare on their low NAME_BYTES bytes only
    localparam logic [NAME_W-1:0] KEY_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    // Action codes
    localparam logic [2:0] ACT_ADD_USER  = 3'd0;
    localparam logic [2:0] ACT_DEL_USER  = 3'd1;
    localparam logic [2:0] ACT_ADD_FILE  = 3'd2;
    localparam logic [2:0] ACT_DEL_FILE  = 3'd3;
    localparam logic [2:0] ACT_FIND_FILE = 3'd4;

    // Status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NO_USER   = 3'd1;
    localparam logic [2:0] STS_USER_DUP  = 3'd2;
    localparam logic [2:0] STS_NO_FILE   = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;

    typedef struct packed {
        logic [2:0]        action;
        logic [NAME_W-1:0] user_name;
        logic [NAME_W-1:0] file_name;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] user_slot;
        logic [3:0] file_slot;
        logic [4:0] users_held;
        logic [4:0] files_held;
    } rsp_t;

endpackage

### design/two_level_name_table_top.sv
// Channel | Dir | Handshake            | Payload
// cmd     | in  | cmd_valid/cmd_stall  | tlnt_pkg::cmd_t (action, user_name, file_name)
// rsp     | out | rsp_valid/rsp_stall  | tlnt_pkg::rsp_t (status, slots, counts)
//
// One transaction at a time; cmd_stall is high from accept until the result is loaded.
// User scan: one user per cycle. File scan: one file per cycle through the
// registered read of the file memory. File delete moves one entry per cycle.
// Deleting a user only rotates a 16-entry slot map: file lists never move.
// Reset clears counts and sets the slot map to identity; names are undefined until written.
// A stalled result holds in the output register; the next result waits for it.
module two_level_name_table_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  tlnt_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tlnt_pkg::rsp_t  rsp
);
    import tlnt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_USCAN  = 5'b00010,
        S_FSCAN  = 5'b00100,
        S_FSHIFT = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          act_reg, act_next;
    logic [NAME_W-1:0]   ukey_reg, ukey_next;
    logic [NAME_W-1:0]   fkey_reg, fkey_next;
    logic [UCNT_W-1:0]   idx_reg, idx_next;
    logic [UIDX_W-1:0]   uhit_reg, uhit_next;
    logic [UIDX_W-1:0]   phys_reg, phys_next;
    logic [FCNT_W-1:0]   rd_reg, rd_next;
    logic                pv_reg, pv_next;
    logic [FIDX_W-1:0]   pidx_reg, pidx_next;
    logic [FIDX_W-1:0]   fhit_reg, fhit_next;
    logic [UCNT_W-1:0]   user_total_reg, user_total_next;
    logic [FCNT_W-1:0]   ftot_reg [MAX_USERS];
    logic [FCNT_W-1:0]   ftot_next [MAX_USERS];
    logic [UIDX_W-1:0]   map_reg [MAX_USERS];
    logic [UIDX_W-1:0]   map_next [MAX_USERS];
    logic [NAME_W-1:0]   user_names_reg [MAX_USERS];
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                uname_we;
    logic [UIDX_W-1:0]   uname_widx;
    logic                mem_we, mem_re;
    logic [FADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [NAME_W-1:0]   mem_wdata, mem_rdata;

    logic [UIDX_W-1:0]   cur_phys;
    logic                u_hit;
    logic                f_hit;
    logic [FCNT_W-1:0]   fcnt;
    logic [FCNT_W-1:0]   f_add;
    logic [UIDX_W-1:0]   new_phys;
    logic [UCNT_W-1:0]   last_idx;

    tlnt_file_mem u_file_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Shared compare paths
    assign cur_phys = map_reg[idx_reg[UIDX_W-1:0]];
    assign u_hit    = (idx_reg < user_total_reg) && (user_names_reg[cur_phys] == ukey_reg);
    assign fcnt     = ftot_reg[phys_reg];
    assign f_hit    = pv_reg && (mem_rdata == fkey_reg);
    assign f_add    = ftot_reg[cur_phys];
    assign new_phys = map_reg[user_total_reg[UIDX_W-1:0]];
    assign last_idx = user_total_reg - UCNT_W'(1);

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        ukey_next       = ukey_reg;
        fkey_next       = fkey_reg;
        idx_next        = idx_reg;
        uhit_next       = uhit_reg;
        phys_next       = phys_reg;
        rd_next         = rd_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        fhit_next       = fhit_reg;
        user_total_next = user_total_reg;
        ftot_next       = ftot_reg;
        map_next        = map_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        uname_we        = 1'b0;
        uname_widx      = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next  = cmd.action;
                    ukey_next = cmd.user_name & KEY_MASK;
                    fkey_next = cmd.file_name & KEY_MASK;
                    idx_next  = '0;
                    if (cmd.action > ACT_FIND_FILE)
                    begin
                        res_next            = '0;
                        res_next.status     = STS_OK;
                        res_next.users_held = 5'(user_total_reg);
                        state_next          = S_RESP;
                    end
                    else
                    begin
                        state_next = S_USCAN;
                    end
                end
            end

            S_USCAN:
            begin
                res_next            = '0;
                res_next.users_held = 5'(user_total_reg);
                if (u_hit)
                begin
                    uhit_next          = idx_reg[UIDX_W-1:0];
                    phys_next          = cur_phys;
                    res_next.user_slot = 4'(idx_reg[UIDX_W-1:0]);
                    case (act_reg)
                        ACT_ADD_USER:
                        begin
                            res_next.status     = STS_USER_DUP;
                            res_next.files_held = 5'(f_add);
                            state_next          = S_RESP;
                        end
                        ACT_DEL_USER:
                        begin
                            // close the gap in the slot map, freed row goes on top
                            for (int j = 0; j < MAX_USERS - 1; j++)
                            begin
                                if ((UCNT_W'(j) >= idx_reg) && (UCNT_W'(j + 1) < user_total_reg))
                                begin
                                    map_next[j] = map_reg[j + 1];
                                end
                            end
                            map_next[last_idx[UIDX_W-1:0]] = cur_phys;
                            ftot_next[cur_phys]  = '0;
                            user_total_next      = last_idx;
                            res_next.status      = STS_OK;
                            res_next.users_held  = 5'(last_idx);
                            state_next           = S_RESP;
                        end
                        ACT_ADD_FILE:
                        begin
                            if (f_add >= FCNT_W'(MAX_FILES))
                            begin
                                res_next.status     = STS_FULL;
                                res_next.files_held = 5'(f_add);
                            end
                            else
                            begin
                                mem_we              = 1'b1;
                                mem_waddr           = {cur_phys, f_add[FIDX_W-1:0]};
                                mem_wdata           = fkey_reg;
                                ftot_next[cur_phys] = f_add + FCNT_W'(1);
                                res_next.status     = STS_OK;
                                res_next.file_slot  = 4'(f_add[FIDX_W-1:0]);
                                res_next.files_held = 5'(f_add + FCNT_W'(1));
                            end
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            rd_next    = '0;
                            pv_next    = 1'b0;
                            state_next = S_FSCAN;
                        end
                    endcase
                end
                else if (idx_reg >= user_total_reg)
                begin
                    if (act_reg == ACT_ADD_USER)
                    begin
                        if (user_total_reg >= UCNT_W'(MAX_USERS))
                        begin
                            res_next.status = STS_FULL;
                        end
                        else
                        begin
                            uname_we            = 1'b1;
                            uname_widx          = new_phys;
                            ftot_next[new_phys] = '0;
                            user_total_next     = user_total_reg + UCNT_W'(1);
                            res_next.status     = STS_OK;
                            res_next.user_slot  = 4'(user_total_reg[UIDX_W-1:0]);
                            res_next.users_held = 5'(user_total_reg + UCNT_W'(1));
                        end
                    end
                    else
                    begin
                        res_next.status = STS_NO_USER;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + UCNT_W'(1);
                end
            end

            S_FSCAN:
            begin
                res_next            = '0;
                res_next.users_held = 5'(user_total_reg);
                res_next.user_slot  = 4'(uhit_reg);
                res_next.files_held = 5'(fcnt);
                if (f_hit)
                begin
                    fhit_next = pidx_reg;
                    if (act_reg == ACT_FIND_FILE)
                    begin
                        res_next.status    = STS_OK;
                        res_next.file_slot = 4'(pidx_reg);
                        state_next         = S_RESP;
                    end
                    else
                    begin
                        rd_next    = FCNT_W'(pidx_reg) + FCNT_W'(1);
                        pv_next    = 1'b0;
                        state_next = S_FSHIFT;
                    end
                end
                else if (!pv_reg && (rd_reg >= fcnt))
                begin
                    res_next.status = STS_NO_FILE;
                    state_next      = S_RESP;
                end
                else if (rd_reg < fcnt)
                begin
                    // stream reads, compare each entry in the cycle after its read
                    mem_re    = 1'b1;
                    mem_raddr = {phys_reg, rd_reg[FIDX_W-1:0]};
                    rd_next   = rd_reg + FCNT_W'(1);
                    pidx_next = rd_reg[FIDX_W-1:0];
                    pv_next   = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
            end

            S_FSHIFT:
            begin
                // write back the entry read last cycle one slot lower
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {phys_reg, pidx_reg - FIDX_W'(1)};
                    mem_wdata = mem_rdata;
                end
                if (rd_reg < fcnt)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {phys_reg, rd_reg[FIDX_W-1:0]};
                    rd_next   = rd_reg + FCNT_W'(1);
                    pidx_next = rd_reg[FIDX_W-1:0];
                    pv_next   = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (!pv_reg && (rd_reg >= fcnt))
                begin
                    ftot_next[phys_reg] = fcnt - FCNT_W'(1);
                    res_next            = '0;
                    res_next.status     = STS_OK;
                    res_next.users_held = 5'(user_total_reg);
                    res_next.user_slot  = 4'(uhit_reg);
                    res_next.file_slot  = 4'(fhit_reg);
                    res_next.files_held = 5'(fcnt - FCNT_W'(1));
                    state_next          = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            user_total_reg <= '0;
            pv_reg         <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int j = 0; j < MAX_USERS; j++)
            begin
                ftot_reg[j] <= '0;
                map_reg[j]  <= UIDX_W'(j);
            end
        end
        else
        begin
            state_reg      <= state_next;
            user_total_reg <= user_total_next;
            pv_reg         <= pv_next;
            rsp_valid_reg  <= rsp_valid_next;
            ftot_reg       <= ftot_next;
            map_reg        <= map_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        ukey_reg <= ukey_next;
        fkey_reg <= fkey_next;
        idx_reg  <= idx_next;
        uhit_reg <= uhit_next;
        phys_reg <= phys_next;
        rd_reg   <= rd_next;
        pidx_reg <= pidx_next;
        fhit_reg <= fhit_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    // User name store, indexed by physical slot
    always_ff @(posedge clk)
    begin
        if (uname_we)
        begin
            user_names_reg[uname_widx] <= ukey_reg;
        end
    end

    // Checks
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        user_total_reg <= UCNT_W'(MAX_USERS))
        else $error("user count above table size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("accepted a second transaction while busy");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_RESP))
        else $error("result appeared outside the response step");

    a_mem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_USCAN || state_reg == S_FSHIFT))
        else $error("file memory written outside add or shift");

    a_shift_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FSHIFT && pv_reg) |-> (pidx_reg != '0))
        else $error("file shift would write below slot zero");

endmodule

### design/tlnt_file_mem.sv
module tlnt_file_mem (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [tlnt_pkg::FADDR_W-1:0]  wr_addr,
    input  logic [tlnt_pkg::NAME_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [tlnt_pkg::FADDR_W-1:0]  rd_addr,
    output logic [tlnt_pkg::NAME_W-1:0]   rd_data
);
    import tlnt_pkg::*;

    // File name store, row = physical user slot, column = file slot
    logic [NAME_W-1:0] mem [2**FADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
